// ===== hdl/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int DIGIT_W = 4;

    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    typedef logic [7:0] t_char;

    localparam t_char CH_ZERO  = 8'd48;
    localparam t_char CH_MINUS = 8'd45;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_stage_ctl;

endpackage

// ===== hdl/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character at a
// time, with a minus sign for negative values and leading zeros removed.
// ----------------------------------------------------------------------------
// Path: a request passes through the input register, the dabble stages at
// four bits each (the last takes the remaining bits), the leading-digit
// register and the emitter, which sends the characters.
// Output: one character per cycle while i_stall is low; a number gives 1 to
// 11 characters at 32 bits. New requests enter while earlier numbers are in
// flight, held off by o_stall while a converted number waits for the emitter.
// Reset: synchronous, active low; it clears all valid bits and the emitter's busy flag.
module signed_binary_to_decimal_ascii #(
    parameter int INPUT_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [INPUT_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_character,
    output logic                         o_last_char
);

    localparam int NDIG_RAW = (INPUT_BITS * 30103 + 99999) / 100000;
    localparam int NDIG     = (NDIG_RAW > 20) ? 20 : ((NDIG_RAW < 1) ? 1 : NDIG_RAW);
    localparam int BCD_W    = NDIG * sbda_pkg::DIGIT_W;
    localparam int IDX_W    = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int BPS      = 4;
    localparam int NSTG     = (INPUT_BITS + BPS - 1) / BPS;
    localparam int LAST_STEPS = INPUT_BITS - (NSTG - 1) * BPS;

    logic                   w_en;
    logic [INPUT_BITS-1:0]  w_raw;
    logic [INPUT_BITS-1:0]  n_in_mag;

    sbda_pkg::t_stage_ctl   w_ctl [0:NSTG];
    logic [BCD_W-1:0]       w_bcd [0:NSTG];
    logic [INPUT_BITS-1:0]  w_mag [0:NSTG];

    logic                   r_in_valid;
    logic                   r_in_neg;
    logic [INPUT_BITS-1:0]  r_in_mag;

    logic [IDX_W-1:0]       n_f_idx;
    logic                   r_f_valid;
    logic                   r_f_neg;
    logic [BCD_W-1:0]       r_f_bcd;
    logic [IDX_W-1:0]       r_f_idx;

    logic                   r_s_busy;
    logic                   r_s_minus;
    logic [BCD_W-1:0]       r_s_bcd;
    logic [IDX_W-1:0]       r_s_idx;
    logic [sbda_pkg::DIGIT_W-1:0] w_digit;
    logic                   w_take;
    logic                   w_cur_last;
    logic                   w_load_ok;

    assign w_cur_last = !r_s_minus && (r_s_idx == '0);
    assign w_take     = r_s_busy && !i_stall;
    assign w_load_ok  = !r_s_busy || (w_take && w_cur_last);
    assign w_en       = !r_f_valid || w_load_ok;
    assign o_stall    = !w_en;

    assign w_raw    = i_value;
    assign n_in_mag = w_raw[INPUT_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_valid;
        end
        if (w_en) begin
            r_in_neg <= w_raw[INPUT_BITS-1];
            r_in_mag <= n_in_mag;
        end
    end

    assign w_ctl[0].valid = r_in_valid;
    assign w_ctl[0].neg   = r_in_neg;
    assign w_bcd[0]       = '0;
    assign w_mag[0]       = r_in_mag;

    for (genvar k = 0; k < NSTG; k++) begin : g_stage
        sbda_dabble_stage #(
            .NDIG     (NDIG),
            .MAG_BITS (INPUT_BITS),
            .STEPS    ((k == NSTG - 1) ? LAST_STEPS : BPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[k]),
            .i_bcd   (w_bcd[k]),
            .i_mag   (w_mag[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_bcd   (w_bcd[k+1]),
            .o_mag   (w_mag[k+1])
        );
    end

    always_comb begin
        n_f_idx = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (w_bcd[NSTG][d*sbda_pkg::DIGIT_W +: sbda_pkg::DIGIT_W] != '0) begin
                n_f_idx = IDX_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (w_en) begin
            r_f_valid <= w_ctl[NSTG].valid;
        end
        if (w_en) begin
            r_f_neg <= w_ctl[NSTG].neg;
            r_f_bcd <= w_bcd[NSTG];
            r_f_idx <= n_f_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_busy <= 1'b0;
        end else if (w_load_ok) begin
            r_s_busy <= r_f_valid;
        end
        if (w_load_ok) begin
            if (r_f_valid) begin
                r_s_minus <= r_f_neg;
                r_s_bcd   <= r_f_bcd;
                r_s_idx   <= r_f_idx;
            end
        end else if (w_take) begin
            if (r_s_minus) begin
                r_s_minus <= 1'b0;
            end else begin
                r_s_idx <= r_s_idx - 1'b1;
            end
        end
    end

    assign w_digit     = r_s_bcd[r_s_idx*sbda_pkg::DIGIT_W +: sbda_pkg::DIGIT_W];
    assign o_valid     = r_s_busy;
    assign o_character = r_s_minus ? sbda_pkg::CH_MINUS
                                   : (sbda_pkg::CH_ZERO + {4'b0000, w_digit});
    assign o_last_char = w_cur_last;

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == sbda_pkg::CH_MINUS) |-> !o_last_char)
        else $error("minus sign flagged as last character");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_char) |=> o_valid)
        else $error("character run broken before its last character");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_f_valid && r_s_busy))
        else $error("input stalled with no item waiting");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_character == sbda_pkg::CH_MINUS ||
                     (o_character >= sbda_pkg::CH_ZERO &&
                      o_character <= sbda_pkg::CH_ZERO + 8'd9)))
        else $error("character is neither a digit nor a minus sign");

endmodule

// ===== hdl/sbda_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// sbda_dabble_stage
// One register stage of the double dabble pipeline: STEPS shift and add-3
// steps on the BCD word, with the magnitude shifted out MSB first.
// ----------------------------------------------------------------------------
module sbda_dabble_stage #(
    parameter int NDIG     = 10,
    parameter int MAG_BITS = 32,
    parameter int STEPS    = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  sbda_pkg::t_stage_ctl                 i_ctl,
    input  logic [NDIG*sbda_pkg::DIGIT_W-1:0]    i_bcd,
    input  logic [MAG_BITS-1:0]                  i_mag,
    output sbda_pkg::t_stage_ctl                 o_ctl,
    output logic [NDIG*sbda_pkg::DIGIT_W-1:0]    o_bcd,
    output logic [MAG_BITS-1:0]                  o_mag
);

    localparam int BCD_W = NDIG * sbda_pkg::DIGIT_W;

    logic [BCD_W-1:0]     n_bcd;
    logic [MAG_BITS-1:0]  n_mag;
    logic                 r_valid;
    logic                 r_neg;
    logic [BCD_W-1:0]     r_bcd;
    logic [MAG_BITS-1:0]  r_mag;

    always_comb begin
        n_bcd = i_bcd;
        n_mag = i_mag;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (n_bcd[d*sbda_pkg::DIGIT_W +: sbda_pkg::DIGIT_W] >= sbda_pkg::DABBLE_LIMIT)
                begin
                    n_bcd[d*sbda_pkg::DIGIT_W +: sbda_pkg::DIGIT_W] =
                        n_bcd[d*sbda_pkg::DIGIT_W +: sbda_pkg::DIGIT_W]
                        + sbda_pkg::DABBLE_ADD;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_mag[MAG_BITS-1]};
            n_mag = {n_mag[MAG_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_neg <= i_ctl.neg;
            r_bcd <= n_bcd;
            r_mag <= n_mag;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.neg   = r_neg;
    assign o_bcd       = r_bcd;
    assign o_mag       = r_mag;

endmodule
